/* src/plane_reflection_matrix_core_macros.svh */
// Assertion macros shared by the checker of the plane reflection core.
// Depends on nothing; the including module must provide clk and rst.
`ifndef PLANE_REFLECTION_MATRIX_CORE_MACROS_SVH
`define PLANE_REFLECTION_MATRIX_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define PRM_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plane reflection check failed");

// Next-cycle implication, also checked across reset.
`define PRM_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("plane reflection check failed");

`endif

/* src/plrefl_pkg.sv */
// Types and step functions for the plane reflection core.
// Depends on nothing; used by plane_reflection_matrix_core.
`default_nettype none

package plrefl_pkg;

  localparam int SQRT_STAGES = 16;
  localparam int DIV_STAGES  = 16;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Data that rides alongside the square root and divider stages.
  typedef struct packed {
    logic             deg;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic [2:0][31:0] pos;
  } side_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] quo;
    logic [31:0] nlo;
  } div_t;

  // One result bit of the digit-by-digit integer square root.
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [63:0] b);
    sqrt_t       r;
    logic [63:0] t;
    t = s.res + b;
    if (s.rem >= t) begin
      r.rem = s.rem - t;
      r.res = (s.res >> 1) + b;
    end else begin
      r.rem = s.rem;
      r.res = s.res >> 1;
    end
    return r;
  endfunction

  // One quotient bit of restoring division by the length.
  function automatic div_t div_step(div_t s, logic [31:0] len);
    div_t        r;
    logic [33:0] t;
    t = {s.rem, s.nlo[31]};
    if (t >= {2'b00, len}) begin
      r.rem = 33'(t - {2'b00, len});
      r.quo = {s.quo[30:0], 1'b1};
    end else begin
      r.rem = t[32:0];
      r.quo = {s.quo[30:0], 1'b0};
    end
    r.nlo = {s.nlo[30:0], 1'b0};
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/plane_reflection_matrix_core.sv */
// Throughput one item per cycle whenever the output register is free or being taken.
// The 32-step square root and the 32-step dividers run two bits per stage.
// The whole pipeline advances together whenever the output register is free
// or being taken. Synchronous reset clears all valid bits; data is not reset.
// Uses plrefl_pkg.
`default_nettype none

module plane_reflection_matrix_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] plane_axis_x,
  input  wire logic signed [31:0] plane_axis_y,
  input  wire logic signed [31:0] plane_axis_z,
  input  wire logic signed [31:0] plane_pos_x,
  input  wire logic signed [31:0] plane_pos_y,
  input  wire logic signed [31:0] plane_pos_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      refl_xx,
  output logic signed [31:0]      refl_yy,
  output logic signed [31:0]      refl_zz,
  output logic signed [31:0]      refl_xy,
  output logic signed [31:0]      refl_xz,
  output logic signed [31:0]      refl_yz,
  output logic signed [39:0]      shift_x,
  output logic signed [39:0]      shift_y,
  output logic signed [39:0]      shift_z,
  output logic                    degenerate
);

  localparam int SQ = plrefl_pkg::SQRT_STAGES;
  localparam int DV = plrefl_pkg::DIV_STAGES;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: magnitudes, signs and the largest magnitude.
  logic                s1_v;
  logic [2:0]          s1_neg;
  logic [2:0][31:0]    s1_mag;
  logic [2:0][31:0]    s1_pos;
  logic [31:0]         s1_mx;
  logic [2:0][31:0]    ax;
  logic [2:0][31:0]    mag_next;
  logic [31:0]         mx_next;

  always_comb begin
    ax = {plane_axis_z, plane_axis_y, plane_axis_x};
    mx_next = '0;
    for (int i = 0; i < 3; i++) begin
      mag_next[i] = ax[i][31] ? 32'(-ax[i]) : ax[i];
      if (mag_next[i] > mx_next) mx_next = mag_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
    if (en) begin
      s1_neg <= {plane_axis_z[31], plane_axis_y[31], plane_axis_x[31]};
      s1_mag <= mag_next;
      s1_pos <= {plane_pos_z, plane_pos_y, plane_pos_x};
      s1_mx  <= mx_next;
    end
  end

  // Stage 2: common left shift that brings the top bit of the largest magnitude up to bit 30.
  logic             s2_v;
  plrefl_pkg::side_t s2_sd;
  logic [4:0]       msb;
  logic [4:0]       kshift;

  always_comb begin
    msb = '0;
    for (int b = 0; b < 32; b++) begin
      if (s1_mx[b]) msb = 5'(b);
    end
    kshift = (msb >= 5'd30) ? 5'd0 : 5'(5'd30 - msb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
    if (en) begin
      s2_sd.deg <= (s1_mx == '0);
      s2_sd.neg <= s1_neg;
      s2_sd.pos <= s1_pos;
      for (int i = 0; i < 3; i++) s2_sd.mag[i] <= s1_mag[i] << kshift;
    end
  end

  // Stage 3: squares. Stage 4: their sum.
  logic              s3_v;
  plrefl_pkg::side_t s3_sd;
  logic [2:0][63:0]  s3_sq;
  logic              s4_v;
  plrefl_pkg::side_t s4_sd;
  logic [63:0]       s4_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
    if (en) begin
      s3_sd <= s2_sd;
      for (int i = 0; i < 3; i++) s3_sq[i] <= s2_sd.mag[i] * s2_sd.mag[i];
      s4_sd  <= s3_sd;
      s4_sum <= s3_sq[0] + s3_sq[1] + s3_sq[2];
    end
  end

  // Square root pipeline, two result bits per stage.
  logic              sq_v  [0:SQ];
  plrefl_pkg::sqrt_t sq_st [0:SQ];
  plrefl_pkg::side_t sq_sd [0:SQ];

  assign sq_v[0]      = s4_v;
  assign sq_st[0].rem = s4_sum;
  assign sq_st[0].res = '0;
  assign sq_sd[0]     = s4_sd;

  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    localparam int B0 = 62 - 4 * g;
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[g+1] <= 1'b0;
      end else if (en) begin
        sq_v[g+1] <= sq_v[g];
      end
      if (en) begin
        sq_st[g+1] <= plrefl_pkg::sqrt_step(
          plrefl_pkg::sqrt_step(sq_st[g], 64'd1 << B0), 64'd1 << (B0 - 2));
        sq_sd[g+1] <= sq_sd[g];
      end
    end
  end

  // Divider lanes, one per axis component, two quotient bits per stage.
  logic                   dv_v   [0:DV];
  logic [31:0]            dv_len [0:DV];
  plrefl_pkg::div_t [2:0] dv_st  [0:DV];
  plrefl_pkg::side_t      dv_sd  [0:DV];
  logic [2:0][61:0]       num;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {sq_sd[SQ].mag[i], 30'd0} + {31'd0, sq_st[SQ].res[31:1]};
      dv_st[0][i].rem = {3'd0, num[i][61:32]};
      dv_st[0][i].quo = '0;
      dv_st[0][i].nlo = num[i][31:0];
    end
  end
  assign dv_v[0]   = sq_v[SQ];
  assign dv_len[0] = sq_st[SQ].res[31:0];
  assign dv_sd[0]  = sq_sd[SQ];

  for (genvar g = 0; g < DV; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[g+1] <= 1'b0;
      end else if (en) begin
        dv_v[g+1] <= dv_v[g];
      end
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_st[g+1][i] <= plrefl_pkg::div_step(
            plrefl_pkg::div_step(dv_st[g][i], dv_len[g]), dv_len[g]);
        end
        dv_len[g+1] <= dv_len[g];
        dv_sd[g+1]  <= dv_sd[g];
      end
    end
  end

  // Products stage: matrix products and position dot terms.
  logic [2:0][30:0]        nm;
  logic signed [2:0][31:0] sn;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nm[i] = (dv_st[DV][i].quo > {1'b0, plrefl_pkg::ONE_Q30})
              ? plrefl_pkg::ONE_Q30 : dv_st[DV][i].quo[30:0];
      sn[i] = dv_sd[DV].neg[i] ? -$signed({1'b0, nm[i]}) : $signed({1'b0, nm[i]});
    end
  end

  logic                    m_v;
  logic                    m_deg;
  logic [2:0]              m_neg;
  logic [2:0][30:0]        m_nm;
  logic [2:0][61:0]        m_diag;
  logic [2:0][61:0]        m_off;
  logic signed [2:0][63:0] m_dp;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= dv_v[DV];
    end
    if (en) begin
      m_deg <= dv_sd[DV].deg;
      m_neg <= dv_sd[DV].neg;
      m_nm  <= nm;
      for (int i = 0; i < 3; i++) begin
        m_diag[i] <= nm[i] * nm[i];
        // Elements of a packed array are unsigned, so both sides are cast.
        m_dp[i]   <= $signed(dv_sd[DV].pos[i]) * $signed(sn[i]);
      end
      m_off[0] <= nm[0] * nm[1];
      m_off[1] <= nm[0] * nm[2];
      m_off[2] <= nm[1] * nm[2];
    end
  end

  // Rounding stage: matrix entries and the distance.
  logic [2:0][31:0] diag_r;
  logic [2:0][31:0] off_r;
  logic [2:0]       off_neg;
  logic [32:0]      rm;
  logic signed [33:0] rv;

  always_comb begin
    off_neg = {m_neg[1] == m_neg[2], m_neg[0] == m_neg[2], m_neg[0] == m_neg[1]};
    for (int i = 0; i < 3; i++) begin
      rm        = 33'((m_diag[i] + 62'h1000_0000) >> 29);
      rv        = 34'sh4000_0000 - $signed({1'b0, rm});
      diag_r[i] = rv[31:0];
      rm        = 33'((m_off[i] + 62'h1000_0000) >> 29);
      rv        = off_neg[i] ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
      off_r[i]  = (rv > 34'sh7FFF_FFFF) ? 32'h7FFF_FFFF : rv[31:0];
    end
  end

  logic                    a_v;
  logic                    a_deg;
  logic [2:0]              a_neg;
  logic [2:0][30:0]        a_nm;
  logic [5:0][31:0]        a_refl;
  logic signed [63:0]      a_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= m_v;
    end
    if (en) begin
      a_deg  <= m_deg;
      a_neg  <= m_neg;
      a_nm   <= m_nm;
      a_refl <= {off_r, diag_r};
      a_d    <= m_dp[0] + m_dp[1] + m_dp[2];
    end
  end

  // Magnitude of the distance.
  logic             b_v;
  logic             b_deg;
  logic [2:0]       b_neg;
  logic [2:0][30:0] b_nm;
  logic [5:0][31:0] b_refl;
  logic [63:0]      b_dmag;
  logic             b_dneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
    if (en) begin
      b_deg  <= a_deg;
      b_neg  <= a_neg;
      b_nm   <= a_nm;
      b_refl <= a_refl;
      b_dneg <= a_d[63];
      b_dmag <= a_d[63] ? 64'(-a_d) : a_d;
    end
  end

  // Shift products, split at bit 30 of the distance.
  logic             c_v;
  logic             c_deg;
  logic [2:0]       c_neg;
  logic [5:0][31:0] c_refl;
  logic             c_dneg;
  logic [2:0][64:0] c_hi;
  logic [2:0][60:0] c_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
    if (en) begin
      c_deg  <= b_deg;
      c_neg  <= b_neg;
      c_refl <= b_refl;
      c_dneg <= b_dneg;
      for (int i = 0; i < 3; i++) begin
        c_hi[i] <= b_dmag[63:30] * b_nm[i];
        c_lo[i] <= b_dmag[29:0] * b_nm[i];
      end
    end
  end

  // Output register with the degenerate override.
  logic [2:0][64:0] sq_q;
  logic [2:0][39:0] sm;
  logic [2:0][39:0] shift_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i]       = c_hi[i] + 65'(c_lo[i] >> 30);
      sm[i]         = 40'((sq_q[i] + 65'h1000_0000) >> 29);
      shift_next[i] = (c_dneg != c_neg[i]) ? 40'(-sm[i]) : sm[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_v;
    end
    if (en) begin
      degenerate <= c_deg;
      if (c_deg) begin
        refl_xx <= 32'sh4000_0000;
        refl_yy <= 32'sh4000_0000;
        refl_zz <= 32'sh4000_0000;
        refl_xy <= '0;
        refl_xz <= '0;
        refl_yz <= '0;
        shift_x <= '0;
        shift_y <= '0;
        shift_z <= '0;
      end else begin
        refl_xx <= c_refl[0];
        refl_yy <= c_refl[1];
        refl_zz <= c_refl[2];
        refl_xy <= c_refl[3];
        refl_xz <= c_refl[4];
        refl_yz <= c_refl[5];
        shift_x <= shift_next[0];
        shift_y <= shift_next[1];
        shift_z <= shift_next[2];
      end
    end
  end

endmodule

`default_nettype wire

/* src/plrefl_checker.sv */
// Port-level checker for the plane reflection core, bound to its top level.
// Depends on plane_reflection_matrix_core_macros.svh.
`default_nettype none
`include "plane_reflection_matrix_core_macros.svh"

module plrefl_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] refl_xx,
  input wire logic signed [31:0] refl_xy,
  input wire logic signed [39:0] shift_x,
  input wire logic signed [39:0] shift_z,
  input wire logic               degenerate
);

  // Nothing comes out in the cycle after reset.
  `PRM_NEXT(a_reset_empty, rst, !out_valid)

  // A waiting result is held until taken.
  `PRM_NEXT(a_hold, !rst && out_valid && !out_ready, out_valid && $stable(refl_xx) && $stable(shift_x))

  // The pipeline only stalls while a result is waiting.
  `PRM_HOLDS(a_ready, !out_valid || out_ready, in_ready)

  // A zero axis gives the identity with no translation.
  `PRM_HOLDS(a_degen, out_valid && degenerate, refl_xx == 32'sh4000_0000 && refl_xy == 32'sd0 && shift_x == 40'sd0 && shift_z == 40'sd0)

endmodule

bind plane_reflection_matrix_core plrefl_checker u_plrefl_checker (.*);

`default_nettype wire

/* test/plane_reflection_matrix_core_tb.sv */
// Self-checking testbench for the plane reflection core: random and corner planes
// against an in-bench fixed-point predictor, with random idling on both channels.
// Depends on the RTL of plane_reflection_matrix_core only.
`default_nettype none

module plane_reflection_matrix_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] xx, yy, zz, xy, xz, yz;
    logic signed [39:0] sx, sy, sz;
    logic               deg;
  } refl_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] plane_axis_x = '0, plane_axis_y = '0, plane_axis_z = '0;
  logic signed [31:0] plane_pos_x = '0, plane_pos_y = '0, plane_pos_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] refl_xx, refl_yy, refl_zz, refl_xy, refl_xz, refl_yz;
  logic signed [39:0] shift_x, shift_y, shift_z;
  logic degenerate;

  refl_t expected_q[$];
  int    errors = 0;
  bit    no_idle = 1'b0;

  always #2 clk = ~clk;

  plane_reflection_matrix_core uut (.*);

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic refl_t predict_reflection(logic signed [31:0] ax[3],
                                                logic signed [31:0] ps[3]);
    refl_t r;
    longint unsigned mag[3], nm[3], mx, sum, len, dmag, dh, dl, q, m;
    longint sn[3], dist_acc;
    bit neg[3], dneg;
    longint v;
    int pi_[3], pj_[3];
    pi_ = '{0, 0, 1};
    pj_ = '{1, 2, 2};
    mx = 0;
    sum = 0;
    dist_acc = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = ax[i] < 0;
      mag[i] = neg[i] ? -longint'(ax[i]) : longint'(ax[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      r.xx = 32'sd1 <<< 30; r.yy = r.xx; r.zz = r.xx;
      r.xy = 0; r.xz = 0; r.yz = 0;
      r.sx = 0; r.sy = 0; r.sz = 0;
      r.deg = 1'b1;
      return r;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      nm[i] = ((mag[i] << 30) + (len >> 1)) / len;
      if (nm[i] > (64'd1 << 30)) nm[i] = 64'd1 << 30;
      sn[i] = neg[i] ? -longint'(nm[i]) : longint'(nm[i]);
    end
    r.xx = sat32((64'sd1 <<< 30) - longint'((nm[0] * nm[0] + (64'd1 << 28)) >> 29));
    r.yy = sat32((64'sd1 <<< 30) - longint'((nm[1] * nm[1] + (64'd1 << 28)) >> 29));
    r.zz = sat32((64'sd1 <<< 30) - longint'((nm[2] * nm[2] + (64'd1 << 28)) >> 29));
    for (int o = 0; o < 3; o++) begin
      v = longint'((nm[pi_[o]] * nm[pj_[o]] + (64'd1 << 28)) >> 29);
      if (neg[pi_[o]] == neg[pj_[o]]) v = -v;
      if (o == 0) r.xy = sat32(v);
      else if (o == 1) r.xz = sat32(v);
      else r.yz = sat32(v);
    end
    for (int i = 0; i < 3; i++) dist_acc += longint'(ps[i]) * sn[i];
    dneg = dist_acc < 0;
    dmag = dneg ? -dist_acc : dist_acc;
    for (int i = 0; i < 3; i++) begin
      dh = dmag >> 30;
      dl = dmag & ((64'd1 << 30) - 1);
      q = dh * nm[i] + ((dl * nm[i]) >> 30);
      m = (q + (64'd1 << 28)) >> 29;
      v = (dneg != neg[i]) ? -longint'(m) : longint'(m);
      if (i == 0) r.sx = v[39:0];
      else if (i == 1) r.sy = v[39:0];
      else r.sz = v[39:0];
    end
    r.deg = 1'b0;
    return r;
  endfunction

  // Sends one plane; valid stays high across back-to-back items.
  task automatic send_plane(logic signed [31:0] ax[3], logic signed [31:0] ps[3]);
    while (!no_idle && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    plane_axis_x <= ax[0]; plane_axis_y <= ax[1]; plane_axis_z <= ax[2];
    plane_pos_x <= ps[0]; plane_pos_y <= ps[1]; plane_pos_z <= ps[2];
    expected_q.push_back(predict_reflection(ax, ps));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    refl_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no plane outstanding");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (refl_xx !== e.xx) begin $error("refl_xx exp %0d got %0d", e.xx, refl_xx); errors++; end
        if (refl_yy !== e.yy) begin $error("refl_yy exp %0d got %0d", e.yy, refl_yy); errors++; end
        if (refl_zz !== e.zz) begin $error("refl_zz exp %0d got %0d", e.zz, refl_zz); errors++; end
        if (refl_xy !== e.xy) begin $error("refl_xy exp %0d got %0d", e.xy, refl_xy); errors++; end
        if (refl_xz !== e.xz) begin $error("refl_xz exp %0d got %0d", e.xz, refl_xz); errors++; end
        if (refl_yz !== e.yz) begin $error("refl_yz exp %0d got %0d", e.yz, refl_yz); errors++; end
        if (shift_x !== e.sx) begin $error("shift_x exp %0d got %0d", e.sx, shift_x); errors++; end
        if (shift_y !== e.sy) begin $error("shift_y exp %0d got %0d", e.sy, shift_y); errors++; end
        if (shift_z !== e.sz) begin $error("shift_z exp %0d got %0d", e.sz, shift_z); errors++; end
        if (degenerate !== e.deg) begin
          $error("degenerate exp %0d got %0d", e.deg, degenerate);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] random_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(200)) - 100);
      3: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_corners();
    logic signed [31:0] ax[3], ps[3];
    logic signed [31:0] ext[5];
    ext = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 1, -1};
    // Zero axis, with the position ignored.
    ax = '{0, 0, 0}; ps = '{32'sh7fff_ffff, 32'sh8000_0000, 5};
    send_plane(ax, ps);
    // Unit axes of both signs, planes built from extreme values, and diagonal planes.
    for (int i = 0; i < 3; i++) begin
      ax = '{0, 0, 0}; ax[i] = 32'sh0001_0000;
      ps = '{32'sh0003_0000, -32'sh0002_0000, 32'sh0001_8000};
      send_plane(ax, ps);
      ax[i] = -32'sh0001_0000;
      send_plane(ax, ps);
    end
    for (int i = 0; i < 5; i++) begin
      ax = '{ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5]};
      ps = '{ext[(i + 3) % 5], ext[(i + 4) % 5], ext[i]};
      send_plane(ax, ps);
    end
    ax = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    ps = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    send_plane(ax, ps);
    ax = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    ps = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    send_plane(ax, ps);
    ax = '{1, 1, 1}; ps = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    send_plane(ax, ps);
    release_input();
  endtask

  task automatic test_random(int count);
    logic signed [31:0] ax[3], ps[3];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 3; i++) begin
        ax[i] = random_word();
        ps[i] = random_word();
      end
      if ($urandom_range(49) == 0) ax = '{0, 0, 0};
      send_plane(ax, ps);
    end
    release_input();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_random(800);
    no_idle = 1'b1;
    test_random(400);
    no_idle = 1'b0;
    test_random(700);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #200us;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
